/* rtl/tef_pkg.sv */
// shared types and constants for the tensor element to fp32 converter
package tef_pkg;

  localparam logic [2:0] ET_FP32  = 3'd0;
  localparam logic [2:0] ET_FP16  = 3'd1;
  localparam logic [2:0] ET_FP64  = 3'd2;
  localparam logic [2:0] ET_INT64 = 3'd3;
  localparam logic [2:0] ET_INT32 = 3'd4;
  localparam logic [2:0] ET_INT8  = 3'd5;
  localparam logic [2:0] ET_UINT8 = 3'd6;
  localparam logic [2:0] ET_BOOL  = 3'd7;

  localparam logic [1:0] SK_RAW   = 2'd0;
  localparam logic [1:0] SK_FLOAT = 2'd1;
  localparam logic [1:0] SK_INT64 = 2'd2;
  localparam logic [1:0] SK_INT32 = 2'd3;

  localparam logic CFG_ELEMENT_TYPE = 1'b0;
  localparam logic CFG_SOURCE_KIND  = 1'b1;

  localparam logic [31:0] ONE_F32 = 32'h3F80_0000;
  localparam logic [31:0] INF_F32 = 32'h7F80_0000;

  // what the decode stage hands to the normaliser
  typedef struct packed {
    logic        direct;   // result already known, take fixed_bits
    logic [31:0] fixed_bits;
    logic        sign;
    logic [63:0] mag;      // nonzero when direct is low
    logic [11:0] exp2;     // signed, value = mag * 2^exp2
    logic        last;
  } dec_t;

  // normalised: mag has its top bit at 63, value = mag * 2^(exp2-63)
  typedef struct packed {
    logic        direct;
    logic [31:0] fixed_bits;
    logic        sign;
    logic [63:0] mag;
    logic [12:0] exp2;     // signed, exponent of the leading one
    logic        last;
  } nrm_t;

endpackage

/* rtl/tef_decode.sv */
// decode stage: select conversion and build sign, magnitude and exponent
module tef_decode (
  input  logic         [2:0]  element_type,
  input  logic         [1:0]  source_kind,
  input  logic         [63:0] element_bits,
  input  logic                last_element,
  output tef_pkg::dec_t       dec
);

  logic [63:0] s32, s8, intv;
  logic        use_int, use_f16, use_f64;

  assign s32 = {{32{element_bits[31]}}, element_bits[31:0]};
  assign s8  = {{56{element_bits[7]}}, element_bits[7:0]};

  always_comb begin
    dec = '0;
    dec.last = last_element;
    use_int = 1'b0;
    use_f16 = 1'b0;
    use_f64 = 1'b0;
    intv = element_bits;
    case (source_kind)
      tef_pkg::SK_RAW: begin
        case (element_type)
          tef_pkg::ET_FP32: begin
            dec.direct = 1'b1;
            dec.fixed_bits = element_bits[31:0];
          end
          tef_pkg::ET_FP16:  use_f16 = 1'b1;
          tef_pkg::ET_FP64:  use_f64 = 1'b1;
          tef_pkg::ET_INT64: use_int = 1'b1;
          tef_pkg::ET_INT32: begin use_int = 1'b1; intv = s32; end
          tef_pkg::ET_INT8:  begin use_int = 1'b1; intv = s8; end
          tef_pkg::ET_UINT8: begin use_int = 1'b1; intv = {56'd0, element_bits[7:0]}; end
          default: begin
            dec.direct = 1'b1;
            dec.fixed_bits = (element_bits[7:0] != 8'd0) ? tef_pkg::ONE_F32 : 32'd0;
          end
        endcase
      end
      tef_pkg::SK_FLOAT: begin
        dec.direct = 1'b1;
        dec.fixed_bits = element_bits[31:0];
      end
      tef_pkg::SK_INT64: use_int = 1'b1;
      default: begin
        if (element_type == tef_pkg::ET_FP16) begin
          use_f16 = 1'b1;
        end else if (element_type == tef_pkg::ET_BOOL) begin
          dec.direct = 1'b1;
          dec.fixed_bits = (element_bits[31:0] != 32'd0) ? tef_pkg::ONE_F32 : 32'd0;
        end else begin
          use_int = 1'b1;
          intv = s32;
        end
      end
    endcase

    if (use_int) begin
      if (intv == 64'd0) begin
        dec.direct = 1'b1;
        dec.fixed_bits = 32'd0;
      end else begin
        dec.sign = intv[63];
        dec.mag  = intv[63] ? (~intv + 64'd1) : intv;
        dec.exp2 = 12'd0;
      end
    end
    if (use_f16) begin
      dec.sign = element_bits[15];
      if (element_bits[14:10] == 5'h1F) begin
        dec.direct = 1'b1;
        dec.fixed_bits = {element_bits[15], 8'hFF, element_bits[9:0], 13'd0};
      end else if (element_bits[14:0] == 15'd0) begin
        dec.direct = 1'b1;
        dec.fixed_bits = {element_bits[15], 31'd0};
      end else if (element_bits[14:10] == 5'd0) begin
        dec.mag  = {54'd0, element_bits[9:0]};
        dec.exp2 = -12'sd24;
      end else begin
        dec.mag  = {53'd0, 1'b1, element_bits[9:0]};
        dec.exp2 = {7'd0, element_bits[14:10]} - 12'd25;
      end
    end
    if (use_f64) begin
      dec.sign = element_bits[63];
      if (element_bits[62:52] == 11'h7FF) begin
        dec.direct = 1'b1;
        if (element_bits[51:0] == 52'd0)
          dec.fixed_bits = {element_bits[63], 8'hFF, 23'd0};
        else
          dec.fixed_bits = {element_bits[63], 8'hFF, 1'b1, element_bits[50:29]};
      end else if (element_bits[62:0] == 63'd0) begin
        dec.direct = 1'b1;
        dec.fixed_bits = {element_bits[63], 31'd0};
      end else if (element_bits[62:52] == 11'd0) begin
        dec.mag  = {12'd0, element_bits[51:0]};
        dec.exp2 = -12'sd1074;
      end else begin
        dec.mag  = {11'd0, 1'b1, element_bits[51:0]};
        dec.exp2 = {1'b0, element_bits[62:52]} - 12'd1075;
      end
    end
  end

endmodule

/* rtl/tef_norm.sv */
// normalise stage: leading-one detect and left shift of the magnitude
module tef_norm (
  input  tef_pkg::dec_t dec,
  output tef_pkg::nrm_t nrm
);

  logic [5:0] lz;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (dec.mag[i]) lz = 6'(63 - i);
    end
    nrm.direct     = dec.direct;
    nrm.fixed_bits = dec.fixed_bits;
    nrm.sign       = dec.sign;
    nrm.last       = dec.last;
    nrm.mag        = dec.mag << lz;
    nrm.exp2       = {dec.exp2[11], dec.exp2} + 13'd63 - {7'd0, lz};
  end

endmodule

/* rtl/tef_round.sv */
// round stage: denormal shift, nearest-even rounding and packing
module tef_round (
  input  tef_pkg::nrm_t nrm,
  output logic [31:0]   result
);

  logic signed [13:0] be;
  logic [6:0]         rsh;
  logic [64:0]        sh;
  logic               sticky, g;
  logic [24:0]        q;
  logic [31:0]        pk;

  always_comb begin
    // biased exponent of leading one
    be = 14'(signed'(nrm.exp2)) + 14'sd127;
    rsh = 7'd0;
    if (be < 14'sd1) begin
      rsh = (be < -14'sd40) ? 7'd41 : 7'(14'sd1 - be);
    end
    sh = {nrm.mag, 1'b0} >> rsh;
    sticky = 1'b0;
    for (int i = 0; i < 64; i++) begin
      if (i < int'(rsh) && nrm.mag[i]) sticky = 1'b1;
    end
    g = sh[40];
    sticky = sticky | (sh[39:0] != 40'd0);
    q = {1'b0, sh[64:41]};
    if (g && (sticky || q[0])) q = q + 25'd1;
    if (be < 14'sd1)
      pk = {8'd0, 24'd0} + {7'd0, q};
    else
      pk = {1'b0, be[7:0] - 8'd1, 23'd0} + {7'd0, q};
    if (be > 14'sd254 || pk >= tef_pkg::INF_F32) pk = tef_pkg::INF_F32;
    if (nrm.direct) result = nrm.fixed_bits;
    else            result = {nrm.sign, pk[30:0]};
  end

endmodule

/* rtl/tensor_element_to_fp32.sv */
// top level of the tensor element to fp32 converter
// Converts one element beat per cycle to an fp32 bit pattern through a three
// stage pipeline: decode, normalise (leading-one shift), round and pack. The
// block takes one beat every cycle while the output is taken; a stall at the
// output holds every stage. unsupported is always zero since every type and
// source pair has a conversion. Configuration writes take effect on the next
// accepted beat and are meant to happen while the pipe is empty.
module tensor_element_to_fp32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // element_bits
  input  logic        in_tlast,   // last_element
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_bits
  output logic        out_tlast,  // last_out
  output logic        out_tuser,  // unsupported
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);

  logic [2:0] etype_r;
  logic [1:0] skind_r;
  tef_pkg::dec_t dec_nxt, dec_r;
  tef_pkg::nrm_t nrm_nxt, nrm_r;
  logic [31:0] res_nxt, res_r;
  logic last_r;
  logic v1_r, v2_r, v3_r;
  logic adv;

  // whole pipe moves when the output slot is free or being emptied
  assign adv       = !v3_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etype_r <= tef_pkg::ET_FP32;
      skind_r <= tef_pkg::SK_RAW;
    end else if (cfg_valid) begin
      if (cfg_index == tef_pkg::CFG_ELEMENT_TYPE) etype_r <= cfg_data;
      else                                       skind_r <= cfg_data[1:0];
    end
  end

  tef_decode u_dec (
    .element_type (etype_r),
    .source_kind  (skind_r),
    .element_bits (in_tdata),
    .last_element (in_tlast),
    .dec          (dec_nxt)
  );

  tef_norm u_nrm (.dec(dec_r), .nrm(nrm_nxt));

  tef_round u_rnd (.nrm(nrm_r), .result(res_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      dec_r  <= dec_nxt;
      nrm_r  <= nrm_nxt;
      res_r  <= res_nxt;
      last_r <= nrm_r.last;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = res_r;
  assign out_tlast  = last_r;
  assign out_tuser  = 1'b0;

endmodule

/* rtl/tef_checker.sv */
// port-level checker for the converter, bound to the top level
module tef_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed under stall");

  a_unsup: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tuser)
    else $error("unsupported flag raised");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && out_tready ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("beat lost in pipe");

endmodule

bind tensor_element_to_fp32 tef_checker u_chk (.*);

/* bench/tb.sv */
// self-checking testbench for the tensor element to fp32 converter
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // clock and reset
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  // element stream into the block
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // element_bits
  logic        in_tlast = 1'b0; // last_element

  // converted stream out of the block
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // result_bits
  logic        out_tlast;       // last_out
  logic        out_tuser;       // unsupported

  // register write channel
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = tef_pkg::CFG_ELEMENT_TYPE;
  logic [2:0]  cfg_data = '0;

  typedef struct packed {
    logic [63:0] bits;
    logic        last;
  } element_t;

  typedef struct packed {
    logic [31:0] f32;
    logic        last;
    logic        unsup;
  } converted_t;

  element_t   pending_elems[$];
  converted_t expected_f32[$];

  // predictor's copy of the two registers
  logic [2:0] cur_type = tef_pkg::ET_FP32;
  logic [1:0] cur_kind = tef_pkg::SK_RAW;

  int unsigned mismatches = 0;
  int unsigned elems_in = 0;
  int unsigned results_out = 0;
  int unsigned idle_cycles = 0;
  int unsigned phases_run = 0;

  tensor_element_to_fp32 dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  // round sgn * mag * 2^e2 to binary32, nearest even; mag is nonzero
  function automatic logic [31:0] round_f32(logic sgn, logic [63:0] mag, longint e2);
    int          p;
    longint      lsb, sh;
    logic [63:0] q, rem, half;
    logic [31:0] s;
    s = {sgn, 31'b0};
    p = 63;
    while (p > 0 && !mag[p]) p--;
    lsb = p + e2 - 23;
    if (lsb < -149) lsb = -149;
    if (lsb + 149 >= 255) return s | tef_pkg::INF_F32;
    sh = lsb - e2;
    if (sh <= 0) begin
      q = mag << (-sh);
    end else if (sh >= 64) begin
      q = (sh == 64 && mag > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
    end else begin
      rem  = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      q    = mag >> sh;
      if (rem > half || (rem == half && q[0])) q++;
    end
    q += 64'(lsb + 149) << 23;
    if (q >= 64'(tef_pkg::INF_F32)) return s | tef_pkg::INF_F32;
    return s | q[31:0];
  endfunction

  function automatic logic [31:0] int_to_f32(logic [63:0] v);
    if (v == 0) return 32'd0;
    if (v[63]) return round_f32(1'b1, ~v + 64'd1, 0);
    return round_f32(1'b0, v, 0);
  endfunction

  function automatic logic [31:0] half_to_f32(logic [15:0] h);
    logic [4:0] e;
    e = h[14:10];
    if (e == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'b0};
    if (e == 0 && h[9:0] == 0) return {h[15], 31'b0};
    if (e == 0) return round_f32(h[15], 64'(h[9:0]), 1 - 25);
    return round_f32(h[15], 64'({1'b1, h[9:0]}), longint'(e) - 25);
  endfunction

  function automatic logic [31:0] double_to_f32(logic [63:0] d);
    logic [10:0] e;
    e = d[62:52];
    if (e == 11'h7FF) begin
      if (d[51:0] == 0) return {d[63], 31'b0} | tef_pkg::INF_F32;
      return {d[63], 8'hFF, 1'b1, d[50:29]};
    end
    if (e == 0 && d[51:0] == 0) return {d[63], 31'b0};
    if (e == 0) return round_f32(d[63], {12'b0, d[51:0]}, 1 - 1075);
    return round_f32(d[63], {11'b0, 1'b1, d[51:0]}, longint'(e) - 1075);
  endfunction

  function automatic converted_t convert_element(element_t el);
    converted_t c;
    logic [63:0] x;
    x = el.bits;
    c.last  = el.last;
    c.unsup = 1'b0;
    case (cur_kind)
      tef_pkg::SK_RAW: begin
        case (cur_type)
          tef_pkg::ET_FP32:  c.f32 = x[31:0];
          tef_pkg::ET_FP16:  c.f32 = half_to_f32(x[15:0]);
          tef_pkg::ET_FP64:  c.f32 = double_to_f32(x);
          tef_pkg::ET_INT64: c.f32 = int_to_f32(x);
          tef_pkg::ET_INT32: c.f32 = int_to_f32({{32{x[31]}}, x[31:0]});
          tef_pkg::ET_INT8:  c.f32 = int_to_f32({{56{x[7]}}, x[7:0]});
          tef_pkg::ET_UINT8: c.f32 = int_to_f32({56'b0, x[7:0]});
          default:           c.f32 = (x[7:0] != 0) ? tef_pkg::ONE_F32 : 32'd0;
        endcase
      end
      tef_pkg::SK_FLOAT: c.f32 = x[31:0];
      tef_pkg::SK_INT64: c.f32 = int_to_f32(x);
      default: begin
        if (cur_type == tef_pkg::ET_FP16)
          c.f32 = half_to_f32(x[15:0]);
        else if (cur_type == tef_pkg::ET_BOOL)
          c.f32 = (x[31:0] != 0) ? tef_pkg::ONE_F32 : 32'd0;
        else
          c.f32 = int_to_f32({{32{x[31]}}, x[31:0]});
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // driver: element beats from the pending queue, with random gaps
  // ---------------------------------------------------------------------
  int unsigned send_gap = 0;
  bit          send_burst = 1'b0;  // burst mode: no gaps at all

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if ($urandom_range(0, 199) == 0) send_burst = ~send_burst;
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_elems.size() > 0) begin
        element_t el;
        el = pending_elems.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= el.bits;
        in_tlast  <= el.last;
        send_gap = send_burst ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: random back-pressure plus one long hold-off to fill the pipe
  // ---------------------------------------------------------------------
  int unsigned recv_hold = 0;
  bit          long_hold_done = 1'b0;
  bit          recv_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) recv_burst = ~recv_burst;
      if (!long_hold_done && results_out >= 200) begin
        long_hold_done = 1'b1;
        recv_hold = 300;  // sender keeps offering meanwhile
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!recv_burst) recv_hold = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: predict on input beats, check on output beats
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tef_pkg::CFG_ELEMENT_TYPE) cur_type <= cfg_data;
        else                                        cur_kind <= cfg_data[1:0];
      end
      if (in_tvalid && in_tready) begin
        expected_f32.insert(expected_f32.size(),
                            convert_element('{bits: in_tdata, last: in_tlast}));
        elems_in++;
      end
      if (out_tvalid && out_tready) begin
        converted_t want;
        results_out++;
        if (expected_f32.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: f32=%h last=%b unsup=%b",
                     out_tdata, out_tlast, out_tuser);
        end else begin
          want = expected_f32.pop_front();
          if (out_tdata !== want.f32 || out_tlast !== want.last ||
              out_tuser !== want.unsup) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch type=%0d kind=%0d: exp %h/%b/%b, got %h/%b/%b",
                       cur_type, cur_kind, want.f32, want.last, want.unsup,
                       out_tdata, out_tlast, out_tuser);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("watchdog: no progress, %0d results outstanding", expected_f32.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  task automatic write_reg(logic idx, logic [2:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait for the pipe to empty, sampled mid-cycle once all updates settle
  task automatic drain();
    while (pending_elems.size() > 0 || in_tvalid || expected_f32.size() > 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_bits();
    logic [63:0] v;
    int unsigned k;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 6))
      0: ;                                              // anything
      1: v = {{40{v[63]}}, v[23:0]};                     // small signed
      2: v = {v[63], 11'(896 + $urandom_range(0, 300) - 40), v[51:0]}; // fp64 around the fp32 range
      3: v = {v[63], ($urandom_range(0, 1) ? 11'h7FF : 11'h000), v[51:0]};
      4: begin                                          // rounding ties
        k = $urandom_range(1, 40);
        v = (v & ~((64'd1 << k) - 64'd1)) | (64'd1 << (k - 1));
      end
      5: v = {{48{v[63]}}, v[15:0]};                     // fp16 heavy low word
      default: v = v >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  logic [63:0] directed[$] = '{
    64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
    64'h7FF0_0000_0000_0000, 64'hFFF8_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
    64'h0000_0000_0000_0001, 64'h3690_0000_0000_0000, 64'h380F_FFFF_E000_0000,
    64'h47EF_FFFF_F000_0000, 64'h0000_7C00, 64'h0000_FC01, 64'h0000_8000,
    64'h0000_0001, 64'h0000_03FF, 64'h0100_0001, 64'h0100_0003, 64'h0000_0080,
    64'h0000_00FF, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000,
    64'hABCD_0000_0000_0100, 64'h0000_0001_0000_0000
  };

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // visit every type and source pair, extremes included
    for (int k = 0; k < 4; k++) begin
      for (int t = 0; t < 8; t++) begin
        write_reg(tef_pkg::CFG_ELEMENT_TYPE, 3'(t));
        write_reg(tef_pkg::CFG_SOURCE_KIND, 3'(k));
        if (k == 0) begin
          foreach (directed[i])
            pending_elems.insert(pending_elems.size(),
              element_t'{bits: directed[i], last: (i == directed.size() - 1)});
        end
        for (int i = 0; i < ((k == 0) ? 20 : 40); i++)
          pending_elems.insert(pending_elems.size(),
            element_t'{bits: rand_bits(), last: ($urandom_range(0, 7) == 0)});
        drain();
        phases_run++;
      end
    end
    $display("covered %0d register settings, %0d elements in, %0d results out",
             phases_run, elems_in, results_out);
    $display("%0d mismatches, long output stall applied: %0d", mismatches, long_hold_done);
    if (mismatches == 0 && expected_f32.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/tef_pkg.sv
rtl/tef_decode.sv
rtl/tef_norm.sv
rtl/tef_round.sv
rtl/tensor_element_to_fp32.sv
rtl/tef_checker.sv
bench/tb.sv
